>>> sv/cbra_pkg.sv
// Package for the chunk bitmap run allocator: command and result words,
// ring slot and ring control structs, opcode and state enums.
// No dependencies.
package cbra_pkg;

    localparam int unsigned CHUNK_W   = 8;
    localparam int unsigned SIZE_W    = 13;
    localparam int unsigned MAP_DEPTH = 256;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [SIZE_W-1:0]  size_bytes;
        logic [CHUNK_W-1:0] start_chunk;
    } cbra_in_t;

    typedef struct packed {
        logic               ok;
        logic [CHUNK_W-1:0] run_start;
    } cbra_out_t;

    // One chunk's worth of ring state.
    typedef struct packed {
        logic used;
        logic tent;
    } slot_t;

    // Ring control, broadcast to every cell but the tail, which sees only shift.
    typedef struct packed {
        logic shift;
        logic clear_tent;
        logic commit;
    } ring_ctl_t;

endpackage

>>> sv/cbra_cell.sv
// One cell of the chunk ring: holds the used and tentative bits of one chunk.
// Depends on cbra_pkg.
module cbra_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  cbra_pkg::ring_ctl_t ctl,
    input  cbra_pkg::slot_t     nb_in,
    output cbra_pkg::slot_t     slot
);
    import cbra_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.shift)
        begin
            // Commit takes the tentative mark before it is dropped.
            slot_next.used = nb_in.used | (ctl.commit & nb_in.tent);
            slot_next.tent = nb_in.tent & ~ctl.clear_tent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

>>> sv/cbra_ring.sv
// Row of chunk cells closed into a ring; the head cell is visible, the tail
// cell is fed from the head logic. Depends on cbra_pkg and cbra_cell.
module cbra_ring #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cbra_pkg::ring_ctl_t ctl,
    input  cbra_pkg::slot_t     tail_in,
    output cbra_pkg::slot_t     head
);
    import cbra_pkg::*;

    slot_t     slots [DEPTH];
    ring_ctl_t tail_ctl;

    // The tail takes the head's finished value, so broadcasts skip it.
    always_comb
    begin
        tail_ctl            = '0;
        tail_ctl.shift      = ctl.shift;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_tail
            cbra_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (tail_ctl),
                .nb_in (tail_in),
                .slot  (slots[i])
            );
        end
        else
        begin : g_body
            cbra_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .nb_in (slots[i+1]),
                .slot  (slots[i])
            );
        end
    end

    assign head = slots[0];

endmodule

>>> sv/chunk_bitmap_run_allocator.sv
// Top level of the chunk bitmap run allocator: command handshake, scan
// sequencer and head-of-ring logic. Depends on cbra_pkg and cbra_ring.
//
// The used map lives in a ring of cells, one per chunk, each holding a used
// and a tentative bit, cleared by reset. A word is taken when start is high
// and busy is low. Every command then rotates the ring exactly once round,
// one chunk past the head per clock; the result strobe follows the lap, and
// the next word can be taken in the cycle after the strobe. A command holds
// the block for one full lap whatever the command or its outcome; the lap
// length is the whole cost. busy stays high from the cycle after acceptance
// until the result has gone out. The result word sits on result for the
// single cycle that done is high and cannot be held off: take it then.
// Allocation marks free chunks tentatively as they pass the head, drops the
// marks when a used chunk or a page start breaks the run, and commits them
// all when the run is long enough in bytes, so the first fitting run inside
// one page wins. A free clears chunks starting at start_chunk, wrapping at
// the end of the pool, until the size is covered.
module chunk_bitmap_run_allocator #(
    parameter int unsigned PAGE_BYTES  = 4096,
    parameter int unsigned CHUNK_BYTES = 64,
    parameter int unsigned POOL_PAGES  = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cbra_pkg::cbra_in_t  cmd,
    output logic                done,
    output cbra_pkg::cbra_out_t result
);
    import cbra_pkg::*;

    localparam int unsigned CPP       = PAGE_BYTES / CHUNK_BYTES;
    localparam int unsigned TOTAL_RAW = POOL_PAGES * CPP;
    localparam int unsigned TOTAL     = (TOTAL_RAW > MAP_DEPTH) ? MAP_DEPTH : TOTAL_RAW;
    localparam bit          POOL_OK   = (TOTAL > 0);
    localparam int unsigned RING      = POOL_OK ? TOTAL : 1;
    localparam int unsigned CPP_R     = (CPP > 0) ? CPP : 1;
    localparam int unsigned IDX_W     = $clog2(CPP_R + 1);
    localparam int unsigned SPAN_W    = $clog2(RING * CHUNK_BYTES + 1);
    localparam int unsigned ACC_W     = (SPAN_W > SIZE_W + 1) ? SPAN_W : SIZE_W + 1;

    localparam logic [ACC_W-1:0]   C_ACC     = ACC_W'(CHUNK_BYTES);
    localparam logic [CHUNK_W-1:0] POS_LAST  = CHUNK_W'(RING - 1);
    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(CPP_R - 1);
    localparam logic [CHUNK_W:0]   RING_EXT  = (CHUNK_W+1)'(RING);
    localparam logic [CHUNK_W:0]   TOTAL_EXT = (CHUNK_W+1)'(TOTAL);

    state_t    state_reg, state_next;
    logic      found_reg, found_next;
    cbra_in_t  cmd_reg, cmd_next;
    logic [CHUNK_W-1:0] pos_reg, pos_next;
    logic [CHUNK_W-1:0] run_reg, run_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    cbra_out_t res_reg, res_next;

    ring_ctl_t ctl;
    slot_t     head;
    slot_t     tail;

    logic accept;
    logic scanning;
    logic last;

    assign accept   = start && !busy;
    assign scanning = (state_reg == ST_SCAN);
    assign last     = (pos_reg == POS_LAST);

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_SCAN;
            ST_SCAN: if (last)  state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: begin busy = 1'b0; done = 1'b0; end
            ST_SCAN: begin busy = 1'b1; done = 1'b0; end
            ST_DONE: begin busy = 1'b1; done = 1'b1; end
            default: begin busy = 1'b1; done = 1'b0; end
        endcase
    end

    // ------------------------------------------------------- head datapath
    always_comb
    begin
        logic [CHUNK_W:0]   d0;
        logic               free_ok;
        logic [ACC_W-1:0]   base;
        logic [ACC_W-1:0]   sum;
        logic [ACC_W-1:0]   size_ext;
        logic               new_run;
        logic               hit;
        logic               clr;

        d0       = (cmd.start_chunk == '0) ? '0 : (RING_EXT - {1'b0, cmd.start_chunk});
        free_ok  = (cmd.size_bytes != '0) && ({1'b0, cmd.start_chunk} < TOTAL_EXT);
        size_ext = ACC_W'(cmd_reg.size_bytes);
        new_run  = (idx_reg == '0) || (acc_reg == '0);
        base     = new_run ? '0 : acc_reg;
        sum      = base + C_ACC;
        hit      = 1'b0;
        clr      = 1'b0;

        ctl        = '0;
        ctl.shift  = scanning;
        tail       = head;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        run_next   = run_reg;
        found_next = found_reg;
        res_next   = res_reg;

        if (accept)
        begin
            cmd_next   = cmd;
            pos_next   = '0;
            idx_next   = '0;
            run_next   = '0;
            found_next = 1'b0;
            if (cmd.op == OP_FREE)
            begin
                // Byte offset of chunk 0 from the first chunk to release.
                acc_next           = ACC_W'(ACC_W'(d0) * C_ACC);
                res_next.ok        = free_ok;
                res_next.run_start = cmd.start_chunk;
            end
            else
            begin
                acc_next = '0;
                res_next = '0;
            end
        end
        else if (scanning)
        begin
            pos_next = pos_reg + 1'b1;
            idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;

            if (cmd_reg.op == OP_ALLOC)
            begin
                if (POOL_OK && !found_reg && (cmd_reg.size_bytes != '0))
                begin
                    if (head.used)
                    begin
                        // Used chunk breaks the run: drop the marks.
                        acc_next       = '0;
                        ctl.clear_tent = 1'b1;
                        tail.tent      = 1'b0;
                    end
                    else
                    begin
                        hit            = (sum >= size_ext);
                        acc_next       = sum;
                        ctl.clear_tent = new_run || hit;
                        ctl.commit     = hit && !new_run;
                        tail.used      = hit;
                        tail.tent      = !hit && !last;
                        if (new_run)
                            run_next = pos_reg;
                        if (hit)
                        begin
                            found_next         = 1'b1;
                            res_next.ok        = 1'b1;
                            res_next.run_start = new_run ? pos_reg : run_reg;
                        end
                    end
                end
                if (last)
                begin
                    ctl.clear_tent = 1'b1;
                    tail.tent      = 1'b0;
                end
            end
            else
            begin
                // Offset restarts at the first chunk; clear while inside the size.
                if (pos_reg == cmd_reg.start_chunk)
                    base = '0;
                else
                    base = acc_reg;
                clr       = res_reg.ok && (base < size_ext);
                acc_next  = base + C_ACC;
                tail.used = head.used & ~clr;
            end
        end
    end

    cbra_ring #(
        .DEPTH (RING)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .tail_in (tail),
        .head    (head)
    );

    // ---------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        run_reg <= run_next;
        res_reg <= res_next;
    end

    assign result = res_reg;

`ifndef SYNTHESIS
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("allocator still busy after result");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not start a scan");

    a_found_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (cmd_reg.op == OP_ALLOC))
        else $error("run found during a free");

    a_start_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.ok && (cmd_reg.op == OP_ALLOC)) |-> (result.run_start <= POS_LAST))
        else $error("allocated run starts outside the pool");
`endif

endmodule
